[design/spdf_pkg.sv]
package spdf_pkg;

    // CRC-16-CCITT, MSB first
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam int ADDRESS_BYTES_DEF = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MARKER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 3'd4;

    // configuration reset values
    localparam logic [7:0] RST_START_MARKER  = 8'd126;
    localparam logic [7:0] RST_END_MARKER    = 8'd127;
    localparam logic [7:0] RST_ESCAPE_MARKER = 8'd125;
    localparam logic [7:0] RST_ESCAPE_MASK   = 8'd32;
    localparam logic [7:0] RST_MAX_PAYLOAD   = 8'd114;

    // result status codes
    localparam logic [2:0] ST_INCOMPLETE = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
    localparam logic [2:0] ST_BAD_CRC    = 3'd3;
    localparam logic [2:0] ST_BAD_END    = 3'd4;

endpackage

[design/spdf_crc16_byte.sv]
module spdf_crc16_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    logic [15:0] c;

    // eight unrolled shift steps of the byte-wide update
    always_comb begin
        c = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & spdf_pkg::CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ spdf_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

[design/stuffed_packet_deframer_crc16.sv]
// Channel   Direction  Handshake                  Payload
// rx        in         i_rx_valid / o_rx_ready    i_rx_data[7:0]
// result    out        o_res_valid / i_res_ready  o_status, o_payload_*, o_frame_*
// cfg       in         i_cfg_we (no wait)         i_cfg_index[2:0], i_cfg_wdata[7:0]
//
// One result per received byte, one byte per cycle while results are drained;
// o_res_valid rises the cycle after acceptance, CRC via an unrolled eight-step network.
// A single result register decouples the sides: rx is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset is synchronous, active low; it returns to idle, clears the frame state
// and reloads the marker, mask and length-limit registers.
module stuffed_packet_deframer_crc16 #(
    parameter int ADDRESS_BYTES = spdf_pkg::ADDRESS_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [spdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_wdata,
    // received bytes
    input  logic                           i_rx_valid,
    output logic                           o_rx_ready,
    input  logic [7:0]                     i_rx_data,
    // results
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic [2:0]                     o_status,
    output logic                           o_payload_valid,
    output logic [7:0]                     o_payload_byte,
    output logic [7:0]                     o_payload_index,
    output logic [63:0]                    o_frame_address,
    output logic [7:0]                     o_frame_type,
    output logic [7:0]                     o_frame_length
);

    localparam int ADDR_W     = ADDRESS_BYTES * 8;
    localparam int ADDR_CNT_W = $clog2(ADDRESS_BYTES + 1);
    localparam int ADDR_IDX_W = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
    localparam logic [ADDR_CNT_W-1:0] ADDR_LAST = ADDR_CNT_W'(ADDRESS_BYTES);
    // length byte + address bytes + type byte precede the payload
    localparam logic [8:0] HDR9  = 9'(ADDRESS_BYTES + 2);
    localparam logic [9:0] HDR10 = 10'(ADDRESS_BYTES + 2);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_ADDRESS = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC1    = 3'd5;
    localparam logic [2:0] PH_CRC2    = 3'd6;
    localparam logic [2:0] PH_END     = 3'd7;

    // configuration registers
    logic [7:0] r_start_marker, r_end_marker, r_escape_marker, r_escape_mask;
    logic [7:0] r_max_payload;

    // frame state
    logic [2:0]            r_phase,       n_phase;
    logic                  r_esc_pend,    n_esc_pend;
    logic [ADDR_CNT_W-1:0] r_addr_cnt,    n_addr_cnt;
    logic [8:0]            r_byte_cnt,    n_byte_cnt;
    logic [7:0]            r_length,      n_length;
    logic [ADDR_W-1:0]     r_address,     n_address;
    logic [7:0]            r_type,        n_type;
    logic [15:0]           r_crc,         n_crc;
    logic [15:0]           r_rx_crc,      n_rx_crc;

    // result register
    logic        r_res_valid;
    logic [2:0]  r_status,   n_status;
    logic        r_pv,       n_pv;
    logic [7:0]  r_pb,       n_pb;
    logic [7:0]  r_pi,       n_pi;
    logic [63:0] r_fa,       n_fa;
    logic [7:0]  r_ft,       n_ft;
    logic [7:0]  r_fl,       n_fl;

    logic        rx_fire;
    logic        is_start, is_escape;
    logic [7:0]  data_byte;
    logic [15:0] crc_upd;
    logic [8:0]  pay_off;
    logic [9:0]  byte_next10;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_fire    = i_rx_valid && o_rx_ready;

    assign is_start  = (i_rx_data == r_start_marker) && !r_esc_pend;
    assign is_escape = (i_rx_data == r_escape_marker) && !r_esc_pend;
    assign data_byte = r_esc_pend ? (i_rx_data ^ r_escape_mask) : i_rx_data;
    assign pay_off   = r_byte_cnt - HDR9;
    assign byte_next10 = {1'b0, r_byte_cnt} + 10'd1;

    spdf_crc16_byte u_crc (
        .i_crc  (r_crc),
        .i_data (data_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        n_phase    = r_phase;
        n_esc_pend = r_esc_pend;
        n_addr_cnt = r_addr_cnt;
        n_byte_cnt = r_byte_cnt;
        n_length   = r_length;
        n_address  = r_address;
        n_type     = r_type;
        n_crc      = r_crc;
        n_rx_crc   = r_rx_crc;
        n_status   = spdf_pkg::ST_INCOMPLETE;
        n_pv       = 1'b0;
        n_pb       = 8'h00;
        n_pi       = 8'h00;
        n_fa       = 64'h0;
        n_ft       = 8'h00;
        n_fl       = 8'h00;

        priority if (is_start) begin
            // restart the frame; start wins over escape when equal
            n_phase    = PH_LENGTH;
            n_byte_cnt = 9'd0;
            n_addr_cnt = '0;
            n_address  = '0;
            n_crc      = spdf_pkg::CRC_INIT;
        end else if (is_escape) begin
            n_esc_pend = 1'b1;
        end else begin
            n_esc_pend = 1'b0;
            unique case (r_phase)
                PH_LENGTH: begin
                    if (data_byte > r_max_payload) begin
                        n_phase  = PH_IDLE;
                        n_status = spdf_pkg::ST_BAD_LENGTH;
                    end else begin
                        n_length   = data_byte;
                        n_crc      = crc_upd;
                        n_byte_cnt = 9'd1;
                        n_addr_cnt = '0;
                        n_phase    = PH_ADDRESS;
                    end
                end
                PH_ADDRESS: begin
                    // little-endian: drop the byte into its lane
                    for (int k = 0; k < ADDRESS_BYTES; k++) begin
                        if (r_addr_cnt[ADDR_IDX_W-1:0] == ADDR_IDX_W'(k)) begin
                            n_address[k*8 +: 8] = r_address[k*8 +: 8] | data_byte;
                        end
                    end
                    n_crc      = crc_upd;
                    n_byte_cnt = r_byte_cnt + 9'd1;
                    n_addr_cnt = r_addr_cnt + ADDR_CNT_W'(1);
                    if (n_addr_cnt >= ADDR_LAST) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type     = data_byte;
                    n_crc      = crc_upd;
                    n_byte_cnt = r_byte_cnt + 9'd1;
                    n_phase    = (r_length == 8'd0) ? PH_CRC1 : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_pv       = 1'b1;
                    n_pb       = data_byte;
                    n_pi       = pay_off[7:0];
                    n_crc      = crc_upd;
                    n_byte_cnt = byte_next10[8:0];
                    if (byte_next10 >= ({2'b00, r_length} + HDR10)) begin
                        n_phase = PH_CRC1;
                    end
                end
                PH_CRC1: begin
                    n_rx_crc = {data_byte, 8'h00};
                    n_phase  = PH_CRC2;
                end
                PH_CRC2: begin
                    n_rx_crc = {r_rx_crc[15:8], data_byte};
                    n_phase  = PH_END;
                end
                PH_END: begin
                    // the raw byte closes the frame, escaped or not
                    n_phase = PH_IDLE;
                    priority if (i_rx_data != r_end_marker) begin
                        n_status = spdf_pkg::ST_BAD_END;
                    end else if (r_crc != r_rx_crc) begin
                        n_status = spdf_pkg::ST_BAD_CRC;
                    end else begin
                        n_status = spdf_pkg::ST_OK;
                        n_fa     = 64'(r_address);
                        n_ft     = r_type;
                        n_fl     = r_length;
                    end
                end
                default: begin
                    // idle: ignore the byte
                end
            endcase
        end
    end

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker  <= spdf_pkg::RST_START_MARKER;
            r_end_marker    <= spdf_pkg::RST_END_MARKER;
            r_escape_marker <= spdf_pkg::RST_ESCAPE_MARKER;
            r_escape_mask   <= spdf_pkg::RST_ESCAPE_MASK;
            r_max_payload   <= spdf_pkg::RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spdf_pkg::CFG_START_MARKER:  r_start_marker  <= i_cfg_wdata;
                spdf_pkg::CFG_END_MARKER:    r_end_marker    <= i_cfg_wdata;
                spdf_pkg::CFG_ESCAPE_MARKER: r_escape_marker <= i_cfg_wdata;
                spdf_pkg::CFG_ESCAPE_MASK:   r_escape_mask   <= i_cfg_wdata;
                spdf_pkg::CFG_MAX_PAYLOAD:   r_max_payload   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // frame state control: advance only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_esc_pend <= 1'b0;
            r_addr_cnt <= '0;
            r_byte_cnt <= 9'd0;
        end else if (rx_fire) begin
            r_phase    <= n_phase;
            r_esc_pend <= n_esc_pend;
            r_addr_cnt <= n_addr_cnt;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    // frame payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length  <= 8'd0;
            r_address <= '0;
            r_type    <= 8'd0;
            r_crc     <= spdf_pkg::CRC_INIT;
            r_rx_crc  <= 16'h0000;
        end else if (rx_fire) begin
            r_length  <= n_length;
            r_address <= n_address;
            r_type    <= n_type;
            r_crc     <= n_crc;
            r_rx_crc  <= n_rx_crc;
        end
    end

    // result register: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (rx_fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire) begin
            r_status <= n_status;
            r_pv     <= n_pv;
            r_pb     <= n_pb;
            r_pi     <= n_pi;
            r_fa     <= n_fa;
            r_ft     <= n_ft;
            r_fl     <= n_fl;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_status        = r_status;
    assign o_payload_valid = r_pv;
    assign o_payload_byte  = r_pb;
    assign o_payload_index = r_pi;
    assign o_frame_address = r_fa;
    assign o_frame_type    = r_ft;
    assign o_frame_length  = r_fl;

    // a pending escape is always consumed by the next byte
    a_escape_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fire && r_esc_pend |=> !r_esc_pend)
        else $error("escape still pending after the next byte");

    // the closing byte returns the deframer to idle
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fire && (r_phase == PH_END) && !is_start && !is_escape |=> r_phase == PH_IDLE)
        else $error("frame did not close after the end byte");

    // the payload phase is entered only with a nonzero length
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_length != 8'd0))
        else $error("payload phase with zero length");

    // a streamed payload byte never carries a final status
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_pv |-> (r_status == spdf_pkg::ST_INCOMPLETE))
        else $error("payload byte reported with a final status");

endmodule

[dv/tb_stuffed_packet_deframer_crc16.sv]
`timescale 1ns / 100ps

module tb_stuffed_packet_deframer_crc16;

    localparam int ADDR_BYTES  = spdf_pkg::ADDRESS_BYTES_DEF;
    // length byte, address bytes and type byte come before the payload
    localparam int HDR_BYTES   = ADDR_BYTES + 2;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int REPORT_MAX  = 10;

    // receive-side frame tracking, one state per field of the frame
    localparam logic [2:0] FR_IDLE    = 3'd0;
    localparam logic [2:0] FR_LENGTH  = 3'd1;
    localparam logic [2:0] FR_ADDRESS = 3'd2;
    localparam logic [2:0] FR_TYPE    = 3'd3;
    localparam logic [2:0] FR_PAYLOAD = 3'd4;
    localparam logic [2:0] FR_CRC_HI  = 3'd5;
    localparam logic [2:0] FR_CRC_LO  = 3'd6;
    localparam logic [2:0] FR_END     = 3'd7;

    // how a generated frame ends
    typedef enum int {FK_GOOD, FK_BAD_CRC, FK_BAD_END, FK_ESC_END, FK_CUT} t_frame_kind;

    // field order matches the output ports so a concatenation fills it
    typedef struct packed {
        logic [2:0]  status;
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic [7:0]  pay_index;
        logic [63:0] address;
        logic [7:0]  frm_type;
        logic [7:0]  frm_len;
    } t_deframe_result;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [spdf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                     i_cfg_wdata = 8'd0;
    logic                           i_rx_valid  = 1'b0;
    logic [7:0]                     i_rx_data   = 8'd0;
    logic                           i_res_ready = 1'b0;
    logic                           o_rx_ready;
    logic                           o_res_valid;
    logic [2:0]                     o_status;
    logic                           o_payload_valid;
    logic [7:0]                     o_payload_byte;
    logic [7:0]                     o_payload_index;
    logic [63:0]                    o_frame_address;
    logic [7:0]                     o_frame_type;
    logic [7:0]                     o_frame_length;

    stuffed_packet_deframer_crc16 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_data       (i_rx_data),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_status        (o_status),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_address (o_frame_address),
        .o_frame_type    (o_frame_type),
        .o_frame_length  (o_frame_length)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Register shadow: the predictor and the frame builder both read it.
    // It only changes while the link is quiet, so every byte is predicted
    // with the settings the block used for it.
    // ------------------------------------------------------------------
    logic [7:0] cfg_start = spdf_pkg::RST_START_MARKER;
    logic [7:0] cfg_end   = spdf_pkg::RST_END_MARKER;
    logic [7:0] cfg_esc   = spdf_pkg::RST_ESCAPE_MARKER;
    logic [7:0] cfg_mask  = spdf_pkg::RST_ESCAPE_MASK;
    logic [7:0] cfg_max   = spdf_pkg::RST_MAX_PAYLOAD;

    // predictor state
    logic [2:0]   fr_phase;
    logic         esc_pending;
    logic [3:0]   addr_cnt;
    logic [8:0]   byte_cnt;
    logic [7:0]   len_reg;
    logic [63:0]  addr_acc;
    logic [7:0]   type_reg;
    logic [15:0]  crc_acc;
    logic [15:0]  crc_rx;

    // byte stream waiting for the driver, and results waiting for the block
    logic [7:0]      link_bytes_q[$];
    logic [7:0]      frame_bytes[$];
    t_deframe_result predicted_results_q[$];

    // idle shaping, set per phase by the sequence
    int rx_gap_max        = 0;
    int res_gap_max       = 0;
    int extra_escape_pct  = 0;

    int fail_count   = 0;
    int results_seen = 0;
    int bytes_sent   = 0;
    int n_ok         = 0;
    int n_bad_len    = 0;
    int n_bad_crc    = 0;
    int n_bad_end    = 0;
    int n_payload    = 0;
    int n_settings   = 1;

    // CRC-16-CCITT, MSB first, one byte at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
            acc = acc[15] ? ((acc << 1) ^ spdf_pkg::CRC_POLY) : (acc << 1);
        return acc;
    endfunction

    task automatic deframer_reset();
        fr_phase    = FR_IDLE;
        esc_pending = 1'b0;
        addr_cnt    = '0;
        byte_cnt    = '0;
        len_reg     = '0;
        addr_acc    = '0;
        type_reg    = '0;
        crc_acc     = spdf_pkg::CRC_INIT;
        crc_rx      = '0;
    endtask

    // Advance the frame tracker by one raw link byte and return the result
    // that the block owes for it.
    function automatic t_deframe_result deframe_byte(input logic [7:0] raw);
        t_deframe_result res;
        logic [7:0]      data;
        res  = '0;
        data = raw;
        if (raw == cfg_start && !esc_pending) begin
            // an unescaped start always restarts, even if it equals the escape
            fr_phase = FR_LENGTH;
            byte_cnt = '0;
            addr_cnt = '0;
            addr_acc = '0;
            crc_acc  = spdf_pkg::CRC_INIT;
        end else if (raw == cfg_esc && !esc_pending) begin
            esc_pending = 1'b1;
        end else begin
            // a pending escape is consumed here, even while idle
            if (esc_pending) begin
                data        = raw ^ cfg_mask;
                esc_pending = 1'b0;
            end
            case (fr_phase)
                FR_LENGTH: begin
                    if (data > cfg_max) begin
                        fr_phase   = FR_IDLE;
                        res.status = spdf_pkg::ST_BAD_LENGTH;
                    end else begin
                        len_reg  = data;
                        crc_acc  = crc16_step(crc_acc, data);
                        byte_cnt = 9'd1;
                        addr_cnt = '0;
                        fr_phase = FR_ADDRESS;
                    end
                end
                FR_ADDRESS: begin
                    // little-endian: the first address byte lands lowest
                    addr_acc = addr_acc | ({56'd0, data} << (8 * addr_cnt[2:0]));
                    crc_acc  = crc16_step(crc_acc, data);
                    byte_cnt = byte_cnt + 9'd1;
                    addr_cnt = addr_cnt + 4'd1;
                    if (addr_cnt >= ADDR_BYTES)
                        fr_phase = FR_TYPE;
                end
                FR_TYPE: begin
                    type_reg = data;
                    crc_acc  = crc16_step(crc_acc, data);
                    byte_cnt = byte_cnt + 9'd1;
                    // zero length goes straight to the CRC bytes
                    if (len_reg == 8'd0)
                        fr_phase = FR_CRC_HI;
                    else
                        fr_phase = FR_PAYLOAD;
                end
                FR_PAYLOAD: begin
                    res.pay_valid = 1'b1;
                    res.pay_byte  = data;
                    res.pay_index = 8'(byte_cnt - 9'(HDR_BYTES));
                    crc_acc       = crc16_step(crc_acc, data);
                    byte_cnt      = byte_cnt + 9'd1;
                    if (int'(byte_cnt) >= int'(len_reg) + HDR_BYTES)
                        fr_phase = FR_CRC_HI;
                end
                FR_CRC_HI: begin
                    crc_rx   = {data, 8'h00};
                    fr_phase = FR_CRC_LO;
                end
                FR_CRC_LO: begin
                    crc_rx[7:0] = data;
                    fr_phase    = FR_END;
                end
                FR_END: begin
                    // the end check looks at the raw byte, escaped or not
                    fr_phase = FR_IDLE;
                    if (raw != cfg_end) begin
                        res.status = spdf_pkg::ST_BAD_END;
                    end else if (crc_acc != crc_rx) begin
                        res.status = spdf_pkg::ST_BAD_CRC;
                    end else begin
                        res.status   = spdf_pkg::ST_OK;
                        res.address  = addr_acc;
                        res.frm_type = type_reg;
                        res.frm_len  = len_reg;
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Frame builder: fills link_bytes_q with stuffed bytes
    // ------------------------------------------------------------------

    // Stuff one frame byte: escape the start and escape markers, and now and then any byte.
    // With start equal to escape no escape is possible, so send it raw.
    task automatic push_stuffed(input logic [7:0] data);
        logic forced;
        forced = ($urandom_range(0, 99) < extra_escape_pct);
        if (cfg_start != cfg_esc && (data == cfg_start || data == cfg_esc || forced)) begin
            frame_bytes.push_back(cfg_esc);
            frame_bytes.push_back(data ^ cfg_mask);
        end else begin
            frame_bytes.push_back(data);
        end
    endtask

    function automatic logic [7:0] pick_payload_byte();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return cfg_start;
        if (pick == 1)
            return cfg_esc;
        if (pick == 2)
            return cfg_end;
        return 8'($urandom);
    endfunction

    // keep most frames short; once in a while go up to the limit
    function automatic logic [7:0] pick_length();
        int hi;
        hi = (cfg_max < 8) ? cfg_max : 8;
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, cfg_max));
        return 8'($urandom_range(0, hi));
    endfunction

    task automatic queue_frame(input logic [7:0] frm_len, input logic [63:0] addr,
                               input logic [7:0] frm_type, input t_frame_kind kind);
        logic [15:0] crc;
        logic [7:0]  data;
        logic [7:0]  end_byte;
        int          keep;
        frame_bytes.delete();
        crc = spdf_pkg::CRC_INIT;
        frame_bytes.push_back(cfg_start);
        push_stuffed(frm_len);
        crc = crc16_step(crc, frm_len);
        for (int i = 0; i < ADDR_BYTES; i++) begin
            data = addr[8*i +: 8];
            push_stuffed(data);
            crc = crc16_step(crc, data);
        end
        push_stuffed(frm_type);
        crc = crc16_step(crc, frm_type);
        for (int i = 0; i < frm_len; i++) begin
            data = pick_payload_byte();
            push_stuffed(data);
            crc = crc16_step(crc, data);
        end
        if (kind == FK_BAD_CRC)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        // CRC goes out high byte first
        push_stuffed(crc[15:8]);
        push_stuffed(crc[7:0]);
        case (kind)
            FK_BAD_END: begin
                do
                    end_byte = 8'($urandom);
                while (end_byte == cfg_end || end_byte == cfg_start || end_byte == cfg_esc);
                frame_bytes.push_back(end_byte);
            end
            FK_ESC_END: begin
                // escape in front of the end byte: the raw value still counts
                frame_bytes.push_back(cfg_esc);
                frame_bytes.push_back(cfg_end);
            end
            default: frame_bytes.push_back(cfg_end);
        endcase
        // a cut frame is abandoned partway and left for the next start
        keep = frame_bytes.size();
        if (kind == FK_CUT)
            keep = $urandom_range(2, frame_bytes.size() - 1);
        for (int i = 0; i < keep; i++)
            link_bytes_q.push_back(frame_bytes[i]);
    endtask

    task automatic queue_noise();
        int n;
        int pick;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                link_bytes_q.push_back(cfg_esc);
            else if (pick == 1)
                link_bytes_q.push_back(cfg_start);
            else
                link_bytes_q.push_back(8'($urandom));
        end
    endtask

    // Mostly well-formed frames with random content, the rest damaged
    // frames, oversize lengths and loose bytes.
    task automatic queue_traffic(input int n_bytes);
        int          pick;
        logic [63:0] addr;
        t_frame_kind kind;
        // open each phase with a frame of the largest allowed length
        queue_frame(cfg_max, {$urandom, $urandom}, 8'($urandom), FK_GOOD);
        while (link_bytes_q.size() < n_bytes) begin
            pick = $urandom_range(0, 99);
            addr = {$urandom, $urandom};
            if (pick % 10 == 0)
                addr = '1;
            else if (pick % 10 == 1)
                addr = '0;
            if (pick < 80) begin
                if (pick < 55)
                    kind = FK_GOOD;
                else if (pick < 62)
                    kind = FK_BAD_CRC;
                else if (pick < 69)
                    kind = FK_BAD_END;
                else if (pick < 74)
                    kind = FK_ESC_END;
                else
                    kind = FK_CUT;
                queue_frame(pick_length(), addr, 8'($urandom), kind);
            end else if (pick < 88 && cfg_max != 8'hFF) begin
                frame_bytes.delete();
                frame_bytes.push_back(cfg_start);
                push_stuffed(8'($urandom_range(cfg_max + 1, 255)));
                foreach (frame_bytes[i])
                    link_bytes_q.push_back(frame_bytes[i]);
            end else begin
                queue_noise();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------

    // Sample at the falling edge: nothing queued, nothing offered and
    // nothing owed means the block is quiet.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (link_bytes_q.size() != 0 || i_rx_valid || predicted_results_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [spdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        // the write lands at this edge; mirror it in the shadow
        i_cfg_we <= 1'b0;
        case (idx)
            spdf_pkg::CFG_START_MARKER:  cfg_start = value;
            spdf_pkg::CFG_END_MARKER:    cfg_end   = value;
            spdf_pkg::CFG_ESCAPE_MARKER: cfg_esc   = value;
            spdf_pkg::CFG_ESCAPE_MASK:   cfg_mask  = value;
            spdf_pkg::CFG_MAX_PAYLOAD:   cfg_max   = value;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [7:0] start_m, input logic [7:0] end_m,
                             input logic [7:0] esc_m, input logic [7:0] mask,
                             input logic [7:0] max_len, input int rx_gap, input int res_gap,
                             input int n_bytes);
        wait_idle();
        cfg_write(spdf_pkg::CFG_START_MARKER, start_m);
        cfg_write(spdf_pkg::CFG_END_MARKER, end_m);
        cfg_write(spdf_pkg::CFG_ESCAPE_MARKER, esc_m);
        cfg_write(spdf_pkg::CFG_ESCAPE_MASK, mask);
        cfg_write(spdf_pkg::CFG_MAX_PAYLOAD, max_len);
        n_settings++;
        rx_gap_max       = rx_gap;
        res_gap_max      = res_gap;
        extra_escape_pct = 6;
        queue_traffic(n_bytes);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer one link byte per transaction from link_bytes_q.
    // Predict the result at the accepting edge, then draw the gap before
    // the next byte.
    // ------------------------------------------------------------------
    int   rx_wait;
    logic rx_offer;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            rx_wait = 0;
            deframer_reset();
        end else begin
            rx_offer = i_rx_valid;
            if (i_rx_valid && o_rx_ready) begin
                predicted_results_q.push_back(deframe_byte(i_rx_data));
                bytes_sent++;
                rx_offer = 1'b0;
                rx_wait  = $urandom_range(0, rx_gap_max);
            end
            // hold valid and data until taken; load the next byte after the gap
            if (!rx_offer && link_bytes_q.size() != 0) begin
                if (rx_wait == 0) begin
                    i_rx_data <= link_bytes_q.pop_front();
                    rx_offer = 1'b1;
                end else begin
                    rx_wait--;
                end
            end
            i_rx_valid <= rx_offer;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transaction against the oldest prediction
    // and draw the receiver's stall before the next one. Once, well into
    // the run, hold ready low for a long stretch while bytes are still
    // queued so the block backs up and drops o_rx_ready.
    // ------------------------------------------------------------------
    int              res_wait  = 0;
    int              hold_left = 0;
    bit              long_hold_done = 1'b0;
    t_deframe_result got;
    t_deframe_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            res_wait = 0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                got = {o_status, o_payload_valid, o_payload_byte, o_payload_index,
                       o_frame_address, o_frame_type, o_frame_length};
                results_seen++;
                if (predicted_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] result with nothing outstanding: status %0d", $time,
                                 got.status);
                end else begin
                    want = predicted_results_q.pop_front();
                    if (want.status == spdf_pkg::ST_OK)
                        n_ok++;
                    else if (want.status == spdf_pkg::ST_BAD_LENGTH)
                        n_bad_len++;
                    else if (want.status == spdf_pkg::ST_BAD_CRC)
                        n_bad_crc++;
                    else if (want.status == spdf_pkg::ST_BAD_END)
                        n_bad_end++;
                    if (want.pay_valid)
                        n_payload++;
                    // packed compare covers every field at its own width
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("[%0t] result %0d wrong (exp/got):", $time, results_seen);
                            $display("  status %0d/%0d pv %b/%b byte %h/%h index %0d/%0d",
                                     want.status, got.status, want.pay_valid, got.pay_valid,
                                     want.pay_byte, got.pay_byte, want.pay_index,
                                     got.pay_index);
                            $display("  addr %h/%h type %h/%h length %0d/%0d",
                                     want.address, got.address, want.frm_type, got.frm_type,
                                     want.frm_len, got.frm_len);
                        end
                    end
                end
                res_wait = $urandom_range(0, res_gap_max);
            end else if (res_wait > 0) begin
                res_wait--;
            end
            if (!long_hold_done && results_seen >= 400 && link_bytes_q.size() > 40) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
                hold_left--;
            i_res_ready <= (res_wait == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves on either side
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("stuffed_packet_deframer_crc16: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] s_m;
        logic [7:0] e_m;
        logic [7:0] x_m;
        logic [7:0] lim;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at reset settings, no extra escapes:
        // loose bytes while idle, an escape in front of a start while idle
        // (start taken as data), escape after escape, an oversize length,
        // then a zero-length frame whose address and type need stuffing.
        extra_escape_pct = 0;
        link_bytes_q.push_back(8'h00);
        link_bytes_q.push_back(8'hFF);
        link_bytes_q.push_back(cfg_esc);
        link_bytes_q.push_back(cfg_start);
        link_bytes_q.push_back(cfg_esc);
        link_bytes_q.push_back(cfg_esc);
        link_bytes_q.push_back(cfg_start);
        link_bytes_q.push_back(8'hFF);
        queue_frame(8'd0, 64'hFF00_7E7D_5A00_A5FF, 8'h7E, FK_GOOD);

        // extremes of every register, with and without idling
        run_phase(8'h00, 8'hFF, 8'h01, 8'hFF, 8'd255, 0, 0, 190);
        run_phase(8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, 10, 0, 190);
        // start equal to escape: the start meaning wins
        run_phase(8'h55, 8'hAA, 8'h55, 8'h20, 8'd20, 0, 10, 190);

        // unused register indexes must change nothing
        wait_idle();
        for (int idx = spdf_pkg::CFG_MAX_PAYLOAD + 1; idx < (1 << spdf_pkg::CFG_IDX_W);
             idx++)
            cfg_write(spdf_pkg::CFG_IDX_W'(idx), 8'($urandom));

        for (int p = 0; p < 5; p++) begin
            s_m = 8'($urandom);
            x_m = 8'($urandom);
            do
                e_m = 8'($urandom);
            while (e_m == s_m);
            lim = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 40));
            run_phase(s_m, e_m, x_m, 8'($urandom), lim, (p % 2) * 10, (p / 2) * 5, 190);
        end

        // back to the reset settings with light idling on both sides
        run_phase(spdf_pkg::RST_START_MARKER, spdf_pkg::RST_END_MARKER,
                  spdf_pkg::RST_ESCAPE_MARKER, spdf_pkg::RST_ESCAPE_MASK,
                  spdf_pkg::RST_MAX_PAYLOAD, 3, 3, 190);

        // drain, then leave room for any stray result
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d link bytes under %0d register settings; checked %0d results.",
                 bytes_sent, n_settings, results_seen);
        $display("Frames: %0d good, %0d oversize, %0d crc error, %0d end error; %0d payload.",
                 n_ok, n_bad_len, n_bad_crc, n_bad_end, n_payload);
        if (fail_count == 0 && predicted_results_q.size() == 0) begin
            $display("stuffed_packet_deframer_crc16: match");
        end else begin
            $display("%0d bad results, %0d still outstanding", fail_count,
                     predicted_results_q.size());
            $display("stuffed_packet_deframer_crc16: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
design/spdf_pkg.sv
design/spdf_crc16_byte.sv
design/stuffed_packet_deframer_crc16.sv
dv/tb_stuffed_packet_deframer_crc16.sv
